FILE: rtl/mtc_pkg.sv
// Shared types and constants for the map tile cache lookup block.
// Used by mtc_lookup and map_tile_fifo_cache_lookup_core; depends on nothing.
package mtc_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_UPDATE
    } lookup_state_t;

    // Corner visiting order.
    localparam logic [1:0] CORNER_MIN         = 2'd0;
    localparam logic [1:0] CORNER_MAX         = 2'd1;
    localparam logic [1:0] CORNER_MIN_X_MAX_Y = 2'd2;
    localparam logic [1:0] CORNER_MAX_X_MIN_Y = 2'd3;

    // One corner's lookup outcome, handed from the lookup engine to the output stage.
    typedef struct packed {
        logic [1:0]  corner;
        logic        hit;
        logic [2:0]  slot;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [7:0]  mask;
        logic        last;
    } corner_result_t;

endpackage

FILE: rtl/mtc_tag_ram.sv
// Tag store of the tile cache: one write port, one read port, registered read data.
// Standalone; no package dependencies.
module mtc_tag_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/mtc_lookup.sv
// Lookup engine: captures a view rectangle, scans the tag store once per corner,
// and keeps the valid, in-view and FIFO ring state. Uses mtc_pkg and mtc_tag_ram.
module mtc_lookup #(
    parameter int CACHE_ENTRIES = 8,
    parameter int TILE_BITS     = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      view_min_x,
    input  logic signed [31:0]      view_min_y,
    input  logic signed [31:0]      view_max_x,
    input  logic signed [31:0]      view_max_y,
    output logic                    res_valid,
    input  logic                    res_ready,
    output mtc_pkg::corner_result_t res
);

    localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(CACHE_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(CACHE_ENTRIES);
    localparam logic [SUM_W-1:0]  RING_SIZE  = SUM_W'(CACHE_ENTRIES);
    localparam logic [31:0]       TILE_CLEAR = ~((32'h1 << TILE_BITS) - 32'h1);

    mtc_pkg::lookup_state_t state_reg, state_next;

    logic [1:0]               corner_reg, corner_next;
    logic [31:0]              mnx_reg, mny_reg, mxx_reg, mxy_reg;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CACHE_ENTRIES-1:0] in_view_reg, in_view_next;
    logic [SLOT_W-1:0]        oldest_reg, oldest_next;
    logic [CNT_W-1:0]         filled_reg, filled_next;
    logic [SLOT_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                     hit_reg, hit_next;
    logic [SLOT_W-1:0]        hit_slot_reg, hit_slot_next;

    logic [31:0]       corner_x, corner_y, origin_x, origin_y;
    logic              ram_wr_en, ram_rd_en;
    logic [SLOT_W-1:0] ram_wr_addr, ram_rd_addr;
    logic [63:0]       ram_rd_data;
    logic              tag_match;
    logic              full;
    logic [SUM_W-1:0]  append_sum;
    logic [SLOT_W-1:0] append_slot, miss_slot, used_slot;
    logic [SLOT_W+2:0] slot_wide;
    logic [CACHE_ENTRIES+7:0] mask_wide;

    mtc_tag_ram #(
        .DEPTH (CACHE_ENTRIES),
        .AW    (SLOT_W),
        .DW    (64)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data ({origin_x, origin_y}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        case (corner_reg)
            mtc_pkg::CORNER_MIN:
            begin
                corner_x = mnx_reg;
                corner_y = mny_reg;
            end
            mtc_pkg::CORNER_MAX:
            begin
                corner_x = mxx_reg;
                corner_y = mxy_reg;
            end
            mtc_pkg::CORNER_MIN_X_MAX_Y:
            begin
                corner_x = mnx_reg;
                corner_y = mxy_reg;
            end
            default:
            begin
                corner_x = mxx_reg;
                corner_y = mny_reg;
            end
        endcase
    end

    assign origin_x  = corner_x & TILE_CLEAR;
    assign origin_y  = corner_y & TILE_CLEAR;
    assign tag_match = valid_reg[pend_idx_reg] && (ram_rd_data == {origin_x, origin_y});

    // Free slot position in the ring; the sum stays below twice the ring size.
    assign full       = (filled_reg == FULL_COUNT);
    assign append_sum = SUM_W'(oldest_reg) + SUM_W'(filled_reg);
    always_comb
    begin
        if (append_sum >= RING_SIZE)
        begin
            append_slot = SLOT_W'(append_sum - RING_SIZE);
        end
        else
        begin
            append_slot = append_sum[SLOT_W-1:0];
        end
    end
    assign miss_slot = full ? oldest_reg : append_slot;
    assign used_slot = hit_reg ? hit_slot_reg : miss_slot;

    always_comb
    begin
        state_next    = state_reg;
        corner_next   = corner_reg;
        valid_next    = valid_reg;
        in_view_next  = in_view_reg;
        oldest_next   = oldest_reg;
        filled_next   = filled_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = miss_slot;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = '0;
        in_stall      = 1'b1;
        res_valid     = 1'b0;

        case (state_reg)
            mtc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    in_view_next = '0;
                    corner_next  = mtc_pkg::CORNER_MIN;
                    state_next   = mtc_pkg::ST_START;
                end
            end
            mtc_pkg::ST_START:
            begin
                ram_rd_en     = 1'b1;
                ram_rd_addr   = '0;
                pend_idx_next = '0;
                state_next    = mtc_pkg::ST_SCAN;
            end
            mtc_pkg::ST_SCAN:
            begin
                // Read data now belongs to pend_idx_reg; fetch the next entry meanwhile.
                if (tag_match)
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = pend_idx_reg;
                    state_next    = mtc_pkg::ST_UPDATE;
                end
                else if (pend_idx_reg == LAST_SLOT)
                begin
                    hit_next   = 1'b0;
                    state_next = mtc_pkg::ST_UPDATE;
                end
                else
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = pend_idx_reg + SLOT_W'(1);
                    pend_idx_next = pend_idx_reg + SLOT_W'(1);
                end
            end
            mtc_pkg::ST_UPDATE:
            begin
                res_valid = 1'b1;
                in_view_next[used_slot] = 1'b1;
                if (!hit_reg)
                begin
                    valid_next[miss_slot] = 1'b1;
                end
                if (res_ready)
                begin
                    if (!hit_reg)
                    begin
                        ram_wr_en = 1'b1;
                        if (full)
                        begin
                            oldest_next = (oldest_reg == LAST_SLOT) ? '0
                                                                    : oldest_reg + SLOT_W'(1);
                        end
                        else
                        begin
                            filled_next = filled_reg + CNT_W'(1);
                        end
                    end
                    if (corner_reg == mtc_pkg::CORNER_MAX_X_MIN_Y)
                    begin
                        state_next = mtc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                        state_next  = mtc_pkg::ST_START;
                    end
                end
                else
                begin
                    in_view_next = in_view_reg;
                    valid_next   = valid_reg;
                end
            end
            default:
            begin
                state_next = mtc_pkg::ST_IDLE;
            end
        endcase
    end

    assign slot_wide = {3'b000, used_slot};
    assign mask_wide = {8'h00, in_view_next};

    always_comb
    begin
        res.corner   = corner_reg;
        res.hit      = hit_reg;
        res.slot     = slot_wide[2:0];
        res.origin_x = origin_x;
        res.origin_y = origin_y;
        res.last     = (corner_reg == mtc_pkg::CORNER_MAX_X_MIN_Y);
        res.mask     = res.last ? mask_wide[7:0] : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mtc_pkg::ST_IDLE;
            corner_reg   <= '0;
            valid_reg    <= '0;
            in_view_reg  <= '0;
            oldest_reg   <= '0;
            filled_reg   <= '0;
            pend_idx_reg <= '0;
            hit_reg      <= 1'b0;
            hit_slot_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            corner_reg   <= corner_next;
            valid_reg    <= valid_next;
            in_view_reg  <= in_view_next;
            oldest_reg   <= oldest_next;
            filled_reg   <= filled_next;
            pend_idx_reg <= pend_idx_next;
            hit_reg      <= hit_next;
            hit_slot_reg <= hit_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mtc_pkg::ST_IDLE && in_valid)
        begin
            mnx_reg <= view_min_x;
            mny_reg <= view_min_y;
            mxx_reg <= view_max_x;
            mxy_reg <= view_max_y;
        end
    end

endmodule

FILE: rtl/map_tile_fifo_cache_lookup_core.sv
// Top level of the map tile cache lookup: output register and load request fields.
// Uses mtc_pkg and mtc_lookup (which holds the tag store mtc_tag_ram).
//
// Each accepted view rectangle gives four result beats, one per corner in the order
// min, max, (min x, max y), (max x, min y). Corners are looked up in a fully
// associative store of CACHE_ENTRIES tile origins held in a single-port-read memory,
// scanned one entry per cycle until the first hit. A miss evicts the oldest entry when
// the store is full. The input stalls while an item is in work; a new rectangle is
// taken as soon as the fourth beat sits in the output register. No clearing pass is
// needed after reset.
module map_tile_fifo_cache_lookup_core #(
    parameter int CACHE_ENTRIES = 8,
    parameter int TILE_BITS     = 12,
    parameter int FOLDER_BITS   = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] view_min_x,
    input  logic signed [31:0] view_min_y,
    input  logic signed [31:0] view_max_x,
    input  logic signed [31:0] view_max_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         corner_number,
    output logic               was_hit,
    output logic [2:0]         slot_used,
    output logic signed [31:0] tile_origin_x,
    output logic signed [31:0] tile_origin_y,
    output logic signed [15:0] folder_x,
    output logic signed [15:0] folder_y,
    output logic [3:0]         tile_in_folder_x,
    output logic [3:0]         tile_in_folder_y,
    output logic [7:0]         in_view_mask,
    output logic               is_last
);

    localparam int          FOLDER_SHIFT = TILE_BITS + FOLDER_BITS;
    localparam logic [31:0] FOLDER_MASK  = (32'h1 << FOLDER_BITS) - 32'h1;

    mtc_pkg::corner_result_t res;
    logic res_valid, res_ready, load;

    logic        out_valid_reg;
    logic [1:0]  corner_reg;
    logic        hit_reg, last_reg;
    logic [2:0]  slot_reg;
    logic [31:0] origin_x_reg, origin_y_reg;
    logic [15:0] folder_x_reg, folder_y_reg;
    logic [3:0]  tif_x_reg, tif_y_reg;
    logic [7:0]  mask_reg;

    logic signed [31:0] fold_x_full, fold_y_full, tile_x_full, tile_y_full;
    logic [31:0]        tif_x_full, tif_y_full;

    mtc_lookup #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .TILE_BITS     (TILE_BITS)
    ) u_lookup (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .view_min_x (view_min_x),
        .view_min_y (view_min_y),
        .view_max_x (view_max_x),
        .view_max_y (view_max_y),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    // Arithmetic shifts of 32 or more leave the sign fill, as required.
    assign fold_x_full = $signed(res.origin_x) >>> FOLDER_SHIFT;
    assign fold_y_full = $signed(res.origin_y) >>> FOLDER_SHIFT;
    assign tile_x_full = $signed(res.origin_x) >>> TILE_BITS;
    assign tile_y_full = $signed(res.origin_y) >>> TILE_BITS;
    assign tif_x_full  = tile_x_full & FOLDER_MASK;
    assign tif_y_full  = tile_y_full & FOLDER_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            corner_reg   <= res.corner;
            hit_reg      <= res.hit;
            slot_reg     <= res.slot;
            origin_x_reg <= res.origin_x;
            origin_y_reg <= res.origin_y;
            mask_reg     <= res.mask;
            last_reg     <= res.last;
            // A hit issues no load request, so its request fields read as zero.
            folder_x_reg <= res.hit ? 16'h0000 : fold_x_full[15:0];
            folder_y_reg <= res.hit ? 16'h0000 : fold_y_full[15:0];
            tif_x_reg    <= res.hit ? 4'h0 : tif_x_full[3:0];
            tif_y_reg    <= res.hit ? 4'h0 : tif_y_full[3:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign corner_number    = corner_reg;
    assign was_hit          = hit_reg;
    assign slot_used        = slot_reg;
    assign tile_origin_x    = origin_x_reg;
    assign tile_origin_y    = origin_y_reg;
    assign folder_x         = folder_x_reg;
    assign folder_y         = folder_y_reg;
    assign tile_in_folder_x = tif_x_reg;
    assign tile_in_folder_y = tif_y_reg;
    assign in_view_mask     = mask_reg;
    assign is_last          = last_reg;

endmodule

FILE: bench/testbench.sv
// Testbench for map_tile_fifo_cache_lookup_core: a short table of view rectangles, then
// panning and random views, each result beat checked against a model of the tile cache.
// Depends on mtc_pkg and the block's RTL.
module testbench;

    localparam int ENTRIES      = 8;
    localparam int TILE_BITS    = 12;
    localparam int FOLDER_BITS  = 4;
    localparam int RANDOM_VIEWS = 360;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_VIEW = 60;
    localparam int REPORT_MAX   = 10;

    localparam logic [31:0] TILE_CLEAR  = ~((32'd1 << TILE_BITS) - 32'd1);
    localparam logic [31:0] FOLDER_MASK = (32'd1 << FOLDER_BITS) - 32'd1;

    typedef struct packed {
        logic [1:0]  corner;
        logic        hit;
        logic [2:0]  slot;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [15:0] folder_x;
        logic [15:0] folder_y;
        logic [3:0]  tile_x;
        logic [3:0]  tile_y;
        logic [7:0]  mask;
        logic        last;
    } tile_beat_t;

    // A view rectangle; where known is set, the hit flags, slots and final mask are
    // typed in and override the model.
    typedef struct packed {
        logic [31:0]     min_x;
        logic [31:0]     min_y;
        logic [31:0]     max_x;
        logic [31:0]     max_y;
        logic            known;
        logic [3:0]      hits;
        logic [3:0][2:0] slots;
        logic [7:0]      mask;
    } view_row_t;

    localparam int NUM_DIRECTED = 15;
    localparam view_row_t VIEW_TABLE [NUM_DIRECTED] = '{
        // Empty store: the first corner loads slot 0, the other three hit it.
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b1, 4'b1110, {3'd0, 3'd0, 3'd0, 3'd0}, 8'h01},
        // Extreme corners: four new tiles in slots 1 to 4.
        '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b1, 4'b0000, {3'd4, 3'd3, 3'd2, 3'd1}, 8'h1E},
        // Fills the store and evicts the oldest entry.
        '{32'h0000_1000, 32'h0000_2000, 32'h0000_3FFF, 32'h0000_4FFF,
          1'b0, 4'b0, 12'h0, 8'h0},
        // First corner hits the oldest entry, which the next miss evicts.
        '{32'h8000_0000, 32'h8000_0000, 32'h1000_0000, 32'h2000_0000,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'hFFFF_F000, 32'hFFFF_F800, 32'hFFFF_FABC, 32'hFFFF_FFFF,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'h0000_0FFF, 32'h0000_0FFF, 32'h0000_1000, 32'h0000_1000,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'hFFFF_0000, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_0000,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'h7FFF_F000, 32'h7FFF_F000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b0, 4'b0, 12'h0, 8'h0},
        '{32'h0000_1000, 32'h0000_2000, 32'h0000_3FFF, 32'h0000_4FFF,
          1'b0, 4'b0, 12'h0, 8'h0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] view_min_x;
    logic signed [31:0] view_min_y;
    logic signed [31:0] view_max_x;
    logic signed [31:0] view_max_y;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         corner_number;
    logic               was_hit;
    logic [2:0]         slot_used;
    logic signed [31:0] tile_origin_x;
    logic signed [31:0] tile_origin_y;
    logic signed [15:0] folder_x;
    logic signed [15:0] folder_y;
    logic [3:0]         tile_in_folder_x;
    logic [3:0]         tile_in_folder_y;
    logic [7:0]         in_view_mask;
    logic               is_last;

    // Model of the tag store.
    logic [31:0] tag_x [ENTRIES];
    logic [31:0] tag_y [ENTRIES];
    logic        cached [ENTRIES];
    logic        shown [ENTRIES];
    int          oldest_entry;
    int          filled_entries;

    tile_beat_t  corner_beats_due [$];
    int          beat_mismatches;
    int          views_sent;

    map_tile_fifo_cache_lookup_core #(
        .CACHE_ENTRIES(ENTRIES),
        .TILE_BITS    (TILE_BITS),
        .FOLDER_BITS  (FOLDER_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .view_min_x      (view_min_x),
        .view_min_y      (view_min_y),
        .view_max_x      (view_max_x),
        .view_max_y      (view_max_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .corner_number   (corner_number),
        .was_hit         (was_hit),
        .slot_used       (slot_used),
        .tile_origin_x   (tile_origin_x),
        .tile_origin_y   (tile_origin_y),
        .folder_x        (folder_x),
        .folder_y        (folder_y),
        .tile_in_folder_x(tile_in_folder_x),
        .tile_in_folder_y(tile_in_folder_y),
        .in_view_mask    (in_view_mask),
        .is_last         (is_last)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Looks up the four corners of one view and queues the beats they should give.
    task automatic lookup_view_corners(input logic [31:0] mnx, input logic [31:0] mny,
                                       input logic [31:0] mxx, input logic [31:0] mxy);
        logic [31:0]        cx [4];
        logic [31:0]        cy [4];
        logic [1:0]         corner_code [4];
        logic signed [31:0] shifted;
        tile_beat_t         b;
        int                 hit_slot;
        int                 slot;
        cx = '{mnx, mxx, mnx, mxx};
        cy = '{mny, mxy, mxy, mny};
        corner_code = '{mtc_pkg::CORNER_MIN, mtc_pkg::CORNER_MAX,
                        mtc_pkg::CORNER_MIN_X_MAX_Y, mtc_pkg::CORNER_MAX_X_MIN_Y};
        for (int s = 0; s < ENTRIES; s++)
            shown[s] = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            b = '0;
            b.corner = corner_code[c];
            b.origin_x = cx[c] & TILE_CLEAR;
            b.origin_y = cy[c] & TILE_CLEAR;
            hit_slot = -1;
            // Scanning downward leaves the lowest matching slot.
            for (int s = ENTRIES - 1; s >= 0; s--)
                if (cached[s] && tag_x[s] == b.origin_x && tag_y[s] == b.origin_y)
                    hit_slot = s;
            if (hit_slot >= 0)
            begin
                b.hit = 1'b1;
                slot = hit_slot;
            end
            else
            begin
                if (filled_entries >= ENTRIES)
                begin
                    slot = oldest_entry;
                    oldest_entry = (oldest_entry + 1) % ENTRIES;
                end
                else
                begin
                    slot = (oldest_entry + filled_entries) % ENTRIES;
                    filled_entries++;
                end
                tag_x[slot] = b.origin_x;
                tag_y[slot] = b.origin_y;
                cached[slot] = 1'b1;
                shifted = signed'(b.origin_x) >>> (TILE_BITS + FOLDER_BITS);
                b.folder_x = shifted[15:0];
                shifted = signed'(b.origin_y) >>> (TILE_BITS + FOLDER_BITS);
                b.folder_y = shifted[15:0];
                shifted = signed'(b.origin_x) >>> TILE_BITS;
                b.tile_x = 4'(shifted & FOLDER_MASK);
                shifted = signed'(b.origin_y) >>> TILE_BITS;
                b.tile_y = 4'(shifted & FOLDER_MASK);
            end
            shown[slot] = 1'b1;
            b.slot = 3'(slot);
            if (c == 3)
            begin
                for (int s = 0; s < ENTRIES && s < 8; s++)
                    b.mask[s] = shown[s];
                b.last = 1'b1;
            end
            corner_beats_due = {corner_beats_due, b};
        end
    endtask

    // Offers one view from the falling edge until the block takes it.
    task automatic send_view(input view_row_t row, input int gap);
        int first;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        view_min_x <= row.min_x;
        view_min_y <= row.min_y;
        view_max_x <= row.max_x;
        view_max_y <= row.max_y;
        do
            @(posedge clk);
        while (in_stall);
        lookup_view_corners(row.min_x, row.min_y, row.max_x, row.max_y);
        if (row.known)
        begin
            first = corner_beats_due.size() - 4;
            for (int c = 0; c < 4; c++)
            begin
                corner_beats_due[first + c].hit  = row.hits[c];
                corner_beats_due[first + c].slot = row.slots[c];
            end
            corner_beats_due[first + 3].mask = row.mask;
        end
        views_sent++;
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input tile_beat_t want,
                                   input tile_beat_t got);
        beat_mismatches++;
        if (beat_mismatches <= REPORT_MAX)
            $display({"%s: expected corner=%0d hit=%0b slot=%0d origin=%h,%h folder=%h,%h ",
                      "tile=%h,%h mask=%h last=%0b; got corner=%0d hit=%0b slot=%0d ",
                      "origin=%h,%h folder=%h,%h tile=%h,%h mask=%h last=%0b"},
                     what, want.corner, want.hit, want.slot, want.origin_x, want.origin_y,
                     want.folder_x, want.folder_y, want.tile_x, want.tile_y, want.mask,
                     want.last, got.corner, got.hit, got.slot, got.origin_x, got.origin_y,
                     got.folder_x, got.folder_y, got.tile_x, got.tile_y, got.mask, got.last);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : cycle_watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : beat_checker
        tile_beat_t got;
        tile_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{corner_number, was_hit, slot_used, tile_origin_x, tile_origin_y,
                        folder_x, folder_y, tile_in_folder_x, tile_in_folder_y,
                        in_view_mask, is_last};
                if (corner_beats_due.size() == 0)
                    report_mismatch("unexpected beat", '0, got);
                else
                begin
                    want = corner_beats_due.pop_front();
                    if (got !== want)
                        report_mismatch("beat mismatch", want, got);
                end
            end
        end
    end

    // Random output stalls, plus one long hold-off that lets the block fill up.
    initial
    begin : stall_driver
        int  stall_left;
        int  run_left;
        bit  held;
        out_stall  = 1'b0;
        stall_left = 0;
        run_left   = 0;
        held       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && views_sent >= HOLD_AT_VIEW)
            begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0 && run_left == 0)
            begin
                stall_left = pick_gap();
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                       : $urandom_range(1, 6);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                run_left--;
            end
        end
    end

    initial
    begin : stimulus
        view_row_t   row;
        logic [31:0] pan_x;
        logic [31:0] pan_y;
        int          gap;
        int          choice;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        view_min_x = '0;
        view_min_y = '0;
        view_max_x = '0;
        view_max_y = '0;
        beat_mismatches = 0;
        views_sent = 0;
        oldest_entry = 0;
        filled_entries = 0;
        for (int s = 0; s < ENTRIES; s++)
        begin
            tag_x[s]  = '0;
            tag_y[s]  = '0;
            cached[s] = 1'b0;
            shown[s]  = 1'b0;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_view(VIEW_TABLE[i], pick_gap());

        // Mostly a view panning around the map, so corners hit and evict; the rest
        // are jumps and fully random rectangles.
        pan_x = $urandom;
        pan_y = $urandom;
        for (int i = 0; i < RANDOM_VIEWS; i++)
        begin
            gap = ((i / 30) % 3 == 1) ? 0 : pick_gap();
            choice = $urandom_range(0, 9);
            row = '0;
            if (choice == 0)
            begin
                row.min_x = $urandom;
                row.min_y = $urandom;
                row.max_x = $urandom;
                row.max_y = $urandom;
            end
            else
            begin
                if (choice == 1)
                begin
                    pan_x = $urandom;
                    pan_y = $urandom;
                end
                else
                begin
                    pan_x = pan_x + $urandom_range(0, 4096) - 32'd2048;
                    pan_y = pan_y + $urandom_range(0, 4096) - 32'd2048;
                end
                row.min_x = pan_x;
                row.min_y = pan_y;
                row.max_x = pan_x + $urandom_range(0, 8191);
                row.max_y = pan_y + $urandom_range(0, 8191);
            end
            send_view(row, gap);
        end
        in_valid <= 1'b0;

        while (corner_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (beat_mismatches == 0 && corner_beats_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
